### sv/sync_length_packet_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync/length packet deframer
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SLDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SLDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sldf_pkg.sv
// ----------------------------------------------------------------------------
// sldf_pkg
// Types and constants shared by the sync/length packet deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sldf_pkg;

  // Field widths
  localparam int SYNC_W          = 32;
  localparam int BYTE_W          = 8;
  localparam int KIND_W          = 2;
  localparam int INDEX_W         = 10;
  localparam int LENGTH_W        = 11;
  localparam int TDATA_W         = 32;
  localparam int NUM_SYNC        = 4;
  localparam int CFG_INDEX_W     = 8;
  localparam int MAX_PAYLOAD_DEF = 1024;

  // Deframer stage
  typedef enum logic [1:0] {
    STAGE_HUNT = 2'd0,
    STAGE_LEN  = 2'd1,
    STAGE_DATA = 2'd2
  } stage_t;

  // Packet kind, in sync match priority order
  typedef enum logic [KIND_W-1:0] {
    KIND_SINGLE   = 2'd0,
    KIND_START    = 2'd1,
    KIND_CONTINUE = 2'd2,
    KIND_END      = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SYNC_SINGLE   = 8'd0,
    REG_SYNC_START    = 8'd1,
    REG_SYNC_CONTINUE = 8'd2,
    REG_SYNC_END      = 8'd3
  } cfg_reg_t;

  // Result kind carried on tuser
  localparam logic RESULT_PAYLOAD   = 1'b0;
  localparam logic RESULT_LEN_ERROR = 1'b1;

  typedef logic [NUM_SYNC-1:0][SYNC_W-1:0] sync_words_t;

  // Sync comparator result
  typedef struct packed {
    logic  hit;
    kind_t kind;
  } match_t;

endpackage

`default_nettype wire

### sv/sldf_sync_match.sv
// ----------------------------------------------------------------------------
// sldf_sync_match
// Compares the hunt window against the four sync words, first match wins.
// ----------------------------------------------------------------------------
`default_nettype none

module sldf_sync_match (
  input  wire logic [sldf_pkg::SYNC_W-1:0] window,
  input  wire sldf_pkg::sync_words_t        sync_words,
  output sldf_pkg::match_t                  match
);

  // Priority: single, start, continue, end
  always_comb begin
    match.hit  = 1'b1;
    match.kind = sldf_pkg::KIND_SINGLE;
    if (window == sync_words[sldf_pkg::KIND_SINGLE]) begin
      match.kind = sldf_pkg::KIND_SINGLE;
    end else if (window == sync_words[sldf_pkg::KIND_START]) begin
      match.kind = sldf_pkg::KIND_START;
    end else if (window == sync_words[sldf_pkg::KIND_CONTINUE]) begin
      match.kind = sldf_pkg::KIND_CONTINUE;
    end else if (window == sync_words[sldf_pkg::KIND_END]) begin
      match.kind = sldf_pkg::KIND_END;
    end else begin
      match.hit = 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/sync_length_packet_deframer.sv
// A result beat is registered: it is on m_tvalid in the cycle after the byte that causes it.
// Throughput: one byte per cycle while s_tready is high; each byte is handled by the
//   stage logic in a single pass and its result lands in one output register.
// s_tready stays high while the output register is empty or being drained.
// Reset (rst, synchronous): hunting with a clear window, sync words zero,
//   no result pending.
// ----------------------------------------------------------------------------
// sync_length_packet_deframer
// Hunts for one of four sync words, gathers a 4-byte big-endian length and
// emits each payload byte tagged with kind, index, length and last flag; rejected lengths give an error beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_packet_deframer #(
  parameter int MAX_PAYLOAD = sldf_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input bytes
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,   // [7:0] rx_byte
  // Result beats
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [sldf_pkg::TDATA_W-1:0]          m_tdata,   // [7:0] payload_byte,
                                                           // [9:8] packet_kind,
                                                           // [19:10] byte_index,
                                                           // [30:20] payload_length,
                                                           // [31] zero
  output logic                                  m_tuser,   // [0] result_kind
  output logic                                  m_tlast,   // last_of_packet
  // Configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sldf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sldf_pkg::SYNC_W-1:0]      cfg_data
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [sldf_pkg::SYNC_W-1:0] MAX_LEN = sldf_pkg::SYNC_W'(MAX_PAYLOAD);

  // State
  sldf_pkg::stage_t                 stage, stage_next;
  logic [sldf_pkg::SYNC_W-1:0]      sync_window, sync_window_next;
  logic [sldf_pkg::SYNC_W-1:0]      length_acc, length_acc_next;
  logic [1:0]                       length_seen, length_seen_next;
  sldf_pkg::kind_t                  current_kind, current_kind_next;
  logic [LEN_W-1:0]                 current_length, current_length_next;
  logic [LEN_W-1:0]                 bytes_received, bytes_received_next;
  sldf_pkg::sync_words_t            sync_words;

  // Per-byte result
  logic                             res_valid;
  logic                             res_kind;
  logic [sldf_pkg::BYTE_W-1:0]      res_byte;
  sldf_pkg::kind_t                  res_pkind;
  logic [sldf_pkg::INDEX_W-1:0]     res_index;
  logic [sldf_pkg::LENGTH_W-1:0]    res_length;
  logic                             res_last;

  logic                             accept;
  logic [sldf_pkg::SYNC_W-1:0]      shifted_window;
  logic [sldf_pkg::SYNC_W-1:0]      shifted_length;
  logic [LEN_W:0]                   count_inc;
  logic [sldf_pkg::SYNC_W-1:0]      index_ext;
  logic [sldf_pkg::SYNC_W-1:0]      length_ext;
  sldf_pkg::match_t                 match;

  assign accept         = s_tvalid && s_tready;
  assign s_tready       = !m_tvalid || m_tready;
  assign cfg_ready      = 1'b1;
  assign shifted_window = {sync_window[sldf_pkg::SYNC_W-9:0], s_tdata};
  assign shifted_length = {length_acc[sldf_pkg::SYNC_W-9:0], s_tdata};
  assign count_inc      = {1'b0, bytes_received} + (LEN_W+1)'(1);
  assign index_ext      = sldf_pkg::SYNC_W'(bytes_received);
  assign length_ext     = sldf_pkg::SYNC_W'(current_length);

  sldf_sync_match u_match (
    .window     (shifted_window),
    .sync_words (sync_words),
    .match      (match)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_words <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (sldf_pkg::cfg_reg_t'(cfg_index))
        sldf_pkg::REG_SYNC_SINGLE:   sync_words[sldf_pkg::KIND_SINGLE]   <= cfg_data;
        sldf_pkg::REG_SYNC_START:    sync_words[sldf_pkg::KIND_START]    <= cfg_data;
        sldf_pkg::REG_SYNC_CONTINUE: sync_words[sldf_pkg::KIND_CONTINUE] <= cfg_data;
        sldf_pkg::REG_SYNC_END:      sync_words[sldf_pkg::KIND_END]      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Next state and result for the byte on s_tdata
  always_comb begin
    stage_next          = stage;
    sync_window_next    = sync_window;
    length_acc_next     = length_acc;
    length_seen_next    = length_seen;
    current_kind_next   = current_kind;
    current_length_next = current_length;
    bytes_received_next = bytes_received;
    res_valid           = 1'b0;
    res_kind            = sldf_pkg::RESULT_PAYLOAD;
    res_byte            = '0;
    res_pkind           = current_kind;
    res_index           = '0;
    res_length          = '0;
    res_last            = 1'b0;
    case (stage)
      sldf_pkg::STAGE_LEN: begin
        length_acc_next  = shifted_length;
        length_seen_next = length_seen + 2'd1;
        if (length_seen == 2'd3) begin
          if (shifted_length == '0 || shifted_length > MAX_LEN) begin
            // rejected length: report and hunt again
            stage_next       = sldf_pkg::STAGE_HUNT;
            sync_window_next = '0;
            res_valid        = 1'b1;
            res_kind         = sldf_pkg::RESULT_LEN_ERROR;
          end else begin
            current_length_next = shifted_length[LEN_W-1:0];
            bytes_received_next = '0;
            stage_next          = sldf_pkg::STAGE_DATA;
          end
        end
      end
      sldf_pkg::STAGE_DATA: begin
        bytes_received_next = count_inc[LEN_W-1:0];
        res_valid           = 1'b1;
        res_byte            = s_tdata;
        res_index           = index_ext[sldf_pkg::INDEX_W-1:0];
        res_length          = length_ext[sldf_pkg::LENGTH_W-1:0];
        res_last            = (count_inc >= {1'b0, current_length});
        if (res_last) begin
          stage_next       = sldf_pkg::STAGE_HUNT;
          sync_window_next = '0;
        end
      end
      default: begin
        // hunting, also the unused stage code
        stage_next       = sldf_pkg::STAGE_HUNT;
        sync_window_next = shifted_window;
        if (match.hit) begin
          current_kind_next   = match.kind;
          length_acc_next     = '0;
          length_seen_next    = '0;
          current_length_next = '0;
          stage_next          = sldf_pkg::STAGE_LEN;
        end
      end
    endcase
  end

  // Stage state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage          <= sldf_pkg::STAGE_HUNT;
      sync_window    <= '0;
      length_acc     <= '0;
      length_seen    <= '0;
      current_kind   <= sldf_pkg::KIND_SINGLE;
      current_length <= '0;
      bytes_received <= '0;
    end else if (accept) begin
      stage          <= stage_next;
      sync_window    <= sync_window_next;
      length_acc     <= length_acc_next;
      length_seen    <= length_seen_next;
      current_kind   <= current_kind_next;
      current_length <= current_length_next;
      bytes_received <= bytes_received_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      m_tdata <= {1'b0, res_length, res_index, res_pkind, res_byte};
      m_tuser <= res_kind;
      m_tlast <= res_last;
    end
  end

endmodule

`default_nettype wire

### sv/sldf_checker.sv
// ----------------------------------------------------------------------------
// sldf_checker
// Port-level checks for the sync/length packet deframer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_length_packet_deframer_assert.svh"

module sldf_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [sldf_pkg::TDATA_W-1:0]     m_tdata,
  input wire logic                             m_tuser,
  input wire logic                             m_tlast
);

  logic                         stalled;
  logic [sldf_pkg::TDATA_W+1:0] out_beat;
  logic                         err_beat;
  logic                         err_clean;
  logic                         last_beat;
  logic                         last_index_ok;

  assign stalled       = m_tvalid && !m_tready;
  assign out_beat      = {m_tdata, m_tuser, m_tlast};
  assign err_beat      = m_tvalid && m_tuser == sldf_pkg::RESULT_LEN_ERROR;
  assign err_clean     = m_tdata[7:0] == 8'd0 && m_tdata[31:10] == 22'd0 && !m_tlast;
  assign last_beat     = m_tvalid && m_tuser == sldf_pkg::RESULT_PAYLOAD && m_tlast;
  assign last_index_ok = m_tdata[19:10] == 10'(m_tdata[30:20] - 11'd1);

  // stalled beat holds
  `SLDF_ASSERT_NEXT(a_hold, clk, rst, stalled, m_tvalid && $stable(out_beat), "stalled beat changed")

  // empty output register never stalls the input
  `SLDF_ASSERT_NOW(a_ready, clk, rst, !m_tvalid, s_tready, "input stalled with output empty")

  // error beats carry only the packet kind
  `SLDF_ASSERT_NOW(a_err_zero, clk, rst, err_beat, err_clean, "error beat carries payload fields")

  // last payload byte sits at length minus one
  `SLDF_ASSERT_NOW(a_last_index, clk, rst, last_beat, last_index_ok, "last index does not match length")

endmodule

bind sync_length_packet_deframer sldf_checker u_sldf_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast)
);

`default_nettype wire
